[design/rgb_led_fading_pwm_macros.svh]
// Assertion helpers for the RGB LED PWM block.
`ifndef RGB_LED_FADING_PWM_MACROS_SVH
`define RGB_LED_FADING_PWM_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RLFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rgb_led_fading_pwm: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define RLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rgb_led_fading_pwm: next-cycle check failed");

`endif

[design/rlfp_pkg.sv]
package rlfp_pkg;

	localparam int OPCODE_W   = 2;
	localparam int LUM_IN_W   = 8;
	localparam int LUM_W      = 7;
	localparam int COLOUR_W   = 8;
	localparam int PERIOD_W   = 16;
	localparam int TICK_W     = 8;
	localparam int STEP_W     = 7;
	localparam int CMP_OUT_W  = 13;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// fraction bits of the luminance reciprocal table
	localparam int RECIP_FRAC = 15;

	localparam logic [LUM_W-1:0]     FULL_LUM     = 7'd100;
	localparam logic [LUM_W-1:0]     DIM_FLOOR    = 7'd2;
	localparam logic [PERIOD_W-1:0]  RESET_PERIOD = 16'd8130;
	localparam logic [TICK_W-1:0]    RESET_TICKS  = 8'd50;
	localparam logic [STEP_W-1:0]    RESET_STEP   = 7'd4;
	localparam logic [CMP_OUT_W-1:0] RESET_DUTY   = 13'd8130;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PWM_CLOCK = 2'd0,
		OP_RAMP_TICK = 2'd1,
		OP_LOAD_LUM  = 2'd2
	} opcode_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_RED       = 3'd0,
		REG_GREEN     = 3'd1,
		REG_BLUE      = 3'd2,
		REG_RAMP_DOWN = 3'd3,
		REG_PERIOD    = 3'd4,
		REG_TICKS     = 3'd5,
		REG_LUM_STEP  = 3'd6
	} cfg_reg_t;

endpackage

[design/rlfp_item_if.sv]
interface rlfp_item_if;
	import rlfp_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [LUM_IN_W-1:0] luminance_value;

	modport source (output valid, output opcode, output luminance_value, input ready);
	modport sink (input valid, input opcode, input luminance_value, output ready);
endinterface

[design/rlfp_result_if.sv]
interface rlfp_result_if;
	import rlfp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 red_pin;
	logic                 green_pin;
	logic                 blue_pin;
	logic [CMP_OUT_W-1:0] red_compare;
	logic [CMP_OUT_W-1:0] green_compare;
	logic [CMP_OUT_W-1:0] blue_compare;
	logic [LUM_W-1:0]     luminance_now;

	modport source (output valid, output red_pin, output green_pin, output blue_pin,
		output red_compare, output green_compare, output blue_compare,
		output luminance_now, input ready);
	modport sink (input valid, input red_pin, input green_pin, input blue_pin,
		input red_compare, input green_compare, input blue_compare,
		input luminance_now, output ready);
endinterface

[design/rlfp_cfg_if.sv]
interface rlfp_cfg_if;
	import rlfp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

[design/rgb_led_fading_pwm.sv]
// Channel   Role   Payload
// item      sink   opcode, luminance_value
// result    source red/green/blue pin, red/green/blue compare, luminance_now
// cfg       sink   addr (register index), data
//
// One item per cycle: counter, ramp and compare refresh finish in the accept cycle
// and land in the result register; the 8 x (COLOUR_SHIFT+16) compare multiply
// through the luminance reciprocal table is the longest path.
// The result register frees the input: an item is taken whenever the result is
// empty or being taken in the same cycle.
// arst_n returns counters, luminance, compares and configuration registers to their
// reset values.
// Config writes are taken every cycle.
`include "rgb_led_fading_pwm_macros.svh"

module rgb_led_fading_pwm #(
	parameter int COUNTER_WIDTH = 16,
	parameter int COLOUR_SHIFT  = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	rlfp_item_if.sink          item,
	rlfp_result_if.source      result,
	rlfp_cfg_if.sink           cfg
);
	import rlfp_pkg::*;

	localparam int DUTY_W  = (COLOUR_W + COLOUR_SHIFT > CMP_OUT_W) ?
		COLOUR_W + COLOUR_SHIFT : CMP_OUT_W;
	localparam int RECIP_W = COLOUR_SHIFT + RECIP_FRAC + 1;
	localparam int PROD_W  = COLOUR_W + RECIP_W;
	localparam int PC_W    = (COUNTER_WIDTH > PERIOD_W) ? COUNTER_WIDTH : PERIOD_W;
	localparam int PD_W    = (COUNTER_WIDTH > DUTY_W) ? COUNTER_WIDTH : DUTY_W;

	typedef logic [RECIP_W-1:0] recip_tab_t [0:100];

	// ceil(l * 2^(COLOUR_SHIFT+RECIP_FRAC) / 100): exact floor for any 8-bit colour
	function automatic recip_tab_t build_recip();
		recip_tab_t  tab;
		logic [63:0] num;
		for (int l = 0; l <= 100; l++) begin
			num    = 64'(l) << (COLOUR_SHIFT + RECIP_FRAC);
			tab[l] = RECIP_W'((num + 64'd99) / 64'd100);
		end
		return tab;
	endfunction

	localparam recip_tab_t RECIP = build_recip();

	// configuration
	logic [COLOUR_W-1:0] red_q, green_q, blue_q;
	logic                ramp_down_q;
	logic [PERIOD_W-1:0] period_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [STEP_W-1:0]   step_q;

	// state
	logic [COUNTER_WIDTH-1:0] cnt_q, cnt_d;
	logic [TICK_W-1:0]        tick_q, tick_d;
	logic [LUM_W-1:0]         lum_q, lum_d;
	logic [DUTY_W-1:0]        red_duty_q, green_duty_q, blue_duty_q;
	logic [DUTY_W-1:0]        red_duty_d, green_duty_d, blue_duty_d;
	logic                     refresh;

	// result register
	logic                 out_valid_q;
	logic                 red_pin_q, green_pin_q, blue_pin_q;
	logic [CMP_OUT_W-1:0] red_cmp_q, green_cmp_q, blue_cmp_q;
	logic [LUM_W-1:0]     lum_out_q;

	logic                 item_fire;
	logic                 cnt_at_end;
	logic [TICK_W-1:0]    tick_inc;
	logic [LUM_W:0]       lum_sum;
	logic [LUM_W-1:0]     lum_up, lum_down, lum_load;
	logic [RECIP_W-1:0]   recip;
	logic [PROD_W-1:0]    red_prod, green_prod, blue_prod;

	assign item.ready = !out_valid_q || result.ready;
	assign item_fire  = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign cnt_at_end = PC_W'(cnt_q) >= PC_W'(period_q);
	assign tick_inc   = tick_q + 1'b1;
	assign lum_sum    = {1'b0, lum_q} + {1'b0, step_q};

	always_comb begin
		if (lum_q < FULL_LUM) begin
			lum_up = (lum_sum > {1'b0, FULL_LUM}) ? FULL_LUM : lum_sum[LUM_W-1:0];
		end else begin
			lum_up = lum_q;
		end
		if (lum_q > DIM_FLOOR) begin
			lum_down = (lum_q > step_q) ? lum_q - step_q : '0;
		end else begin
			lum_down = lum_q;
		end
		lum_load = (item.luminance_value > LUM_IN_W'(FULL_LUM)) ?
			FULL_LUM : item.luminance_value[LUM_W-1:0];
	end

	always_comb begin
		cnt_d   = cnt_q;
		tick_d  = tick_q;
		lum_d   = lum_q;
		refresh = 1'b0;
		unique case (opcode_t'(item.opcode))
			OP_PWM_CLOCK: begin
				cnt_d = cnt_at_end ? '0 : cnt_q + 1'b1;
			end
			OP_RAMP_TICK: begin
				if (tick_inc >= ticks_q) begin
					tick_d  = '0;
					lum_d   = ramp_down_q ? lum_down : lum_up;
					refresh = 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			OP_LOAD_LUM: begin
				lum_d = lum_load;
			end
			default: begin
			end
		endcase
	end

	// compare = (colour << COLOUR_SHIFT) * lum / 100 via the reciprocal table
	assign recip      = RECIP[lum_d];
	assign red_prod   = PROD_W'(red_q) * PROD_W'(recip);
	assign green_prod = PROD_W'(green_q) * PROD_W'(recip);
	assign blue_prod  = PROD_W'(blue_q) * PROD_W'(recip);

	assign red_duty_d   = refresh ? DUTY_W'(red_prod >> RECIP_FRAC) : red_duty_q;
	assign green_duty_d = refresh ? DUTY_W'(green_prod >> RECIP_FRAC) : green_duty_q;
	assign blue_duty_d  = refresh ? DUTY_W'(blue_prod >> RECIP_FRAC) : blue_duty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			ramp_down_q <= 1'b1;
			period_q    <= RESET_PERIOD;
			ticks_q     <= RESET_TICKS;
			step_q      <= RESET_STEP;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.addr))
				REG_RED:       red_q       <= cfg.data[COLOUR_W-1:0];
				REG_GREEN:     green_q     <= cfg.data[COLOUR_W-1:0];
				REG_BLUE:      blue_q      <= cfg.data[COLOUR_W-1:0];
				REG_RAMP_DOWN: ramp_down_q <= cfg.data[0];
				REG_PERIOD:    period_q    <= cfg.data[PERIOD_W-1:0];
				REG_TICKS:     ticks_q     <= cfg.data[TICK_W-1:0];
				REG_LUM_STEP:  step_q      <= cfg.data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			tick_q       <= '0;
			lum_q        <= FULL_LUM;
			red_duty_q   <= DUTY_W'(RESET_DUTY);
			green_duty_q <= DUTY_W'(RESET_DUTY);
			blue_duty_q  <= DUTY_W'(RESET_DUTY);
			out_valid_q  <= 1'b0;
		end else begin
			if (item_fire) begin
				cnt_q        <= cnt_d;
				tick_q       <= tick_d;
				lum_q        <= lum_d;
				red_duty_q   <= red_duty_d;
				green_duty_q <= green_duty_d;
				blue_duty_q  <= blue_duty_d;
				out_valid_q  <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (item_fire) begin
			red_pin_q   <= PD_W'(cnt_d) < PD_W'(red_duty_d);
			green_pin_q <= PD_W'(cnt_d) < PD_W'(green_duty_d);
			blue_pin_q  <= PD_W'(cnt_d) < PD_W'(blue_duty_d);
			red_cmp_q   <= red_duty_d[CMP_OUT_W-1:0];
			green_cmp_q <= green_duty_d[CMP_OUT_W-1:0];
			blue_cmp_q  <= blue_duty_d[CMP_OUT_W-1:0];
			lum_out_q   <= lum_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.red_pin       = red_pin_q;
	assign result.green_pin     = green_pin_q;
	assign result.blue_pin      = blue_pin_q;
	assign result.red_compare   = red_cmp_q;
	assign result.green_compare = green_cmp_q;
	assign result.blue_compare  = blue_cmp_q;
	assign result.luminance_now = lum_out_q;

	`RLFP_ASSERT_NOW(a_lum_range, clk, arst_n, 1'b1, lum_q <= FULL_LUM)
	`RLFP_ASSERT_NOW(a_lum_reported, clk, arst_n, out_valid_q, lum_out_q == lum_q)
	`RLFP_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, item_fire, out_valid_q)
	`RLFP_ASSERT_NEXT(a_cnt_in_period, clk, arst_n,
		item_fire && (item.opcode == OP_PWM_CLOCK),
		PC_W'(cnt_q) <= PC_W'($past(period_q)))

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import rlfp_pkg::*;

	localparam int COLOUR_SHIFT = 5;
	localparam int LONG_HOLD = 300;
	// the opcode field is two bits wide; the spare code must leave the state alone
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [LUM_IN_W-1:0] lum_load;
	} led_cmd_t;

	typedef struct packed {
		logic                 red_pin;
		logic                 green_pin;
		logic                 blue_pin;
		logic [CMP_OUT_W-1:0] red_cmp;
		logic [CMP_OUT_W-1:0] green_cmp;
		logic [CMP_OUT_W-1:0] blue_cmp;
		logic [LUM_W-1:0]     lum;
	} led_state_t;

	logic clk = 1'b0;
	logic arst_n;

	rlfp_item_if   item_bus();
	rlfp_result_if result_bus();
	rlfp_cfg_if    cfg_bus();

	rgb_led_fading_pwm #(
		.COUNTER_WIDTH(PERIOD_W),
		.COLOUR_SHIFT (COLOUR_SHIFT)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_bus),
		.result(result_bus),
		.cfg   (cfg_bus)
	);

	always #6 clk = ~clk;

	led_cmd_t   pending_cmds[$];
	led_state_t led_state_q[$];

	int  fail_count;
	int  results_checked;
	int  reg_writes;
	int  settings_applied;
	int  cmd_count[4];
	int  hold_requests;
	int  hold_served;
	int  gap_left;
	int  stall_left;
	logic quiet_phase;

	// predictor state and its copy of the registers
	logic [PERIOD_W-1:0] pwm_count;
	logic [TICK_W-1:0]   tick_count;
	logic [LUM_W-1:0]    lum_pct;
	logic [15:0]         duty_r, duty_g, duty_b;
	logic [COLOUR_W-1:0] colour_r, colour_g, colour_b;
	logic                dim_mode;
	logic [PERIOD_W-1:0] period_cfg;
	logic [TICK_W-1:0]   ticks_cfg;
	logic [STEP_W-1:0]   step_cfg;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] scale_colour(logic [COLOUR_W-1:0] colour);
		int unsigned prod;
		prod = ((32'(colour) << COLOUR_SHIFT) * 32'(lum_pct)) / 32'(FULL_LUM);
		return prod[15:0];
	endfunction

	function automatic led_state_t advance_led_model(led_cmd_t cmd);
		led_state_t  res;
		int unsigned lum_sum;
		case (cmd.opcode)
		OP_PWM_CLOCK: begin
			if (pwm_count >= period_cfg)
				pwm_count = '0;
			else
				pwm_count = pwm_count + 1'b1;
		end
		OP_RAMP_TICK: begin
			tick_count = tick_count + 1'b1;
			if (tick_count >= ticks_cfg) begin
				tick_count = '0;
				if (!dim_mode) begin
					if (lum_pct < FULL_LUM) begin
						lum_sum = 32'(lum_pct) + 32'(step_cfg);
						lum_pct = (lum_sum > 32'(FULL_LUM)) ? FULL_LUM : lum_sum[LUM_W-1:0];
					end
				end else if (lum_pct > DIM_FLOOR) begin
					lum_pct = (lum_pct > step_cfg) ? lum_pct - step_cfg : '0;
				end
				// refresh on every step, even if the luminance held
				duty_r = scale_colour(colour_r);
				duty_g = scale_colour(colour_g);
				duty_b = scale_colour(colour_b);
			end
		end
		OP_LOAD_LUM: begin
			lum_pct = (cmd.lum_load > FULL_LUM) ? FULL_LUM : cmd.lum_load[LUM_W-1:0];
		end
		default: begin
		end
		endcase
		res.red_pin   = pwm_count < duty_r;
		res.green_pin = pwm_count < duty_g;
		res.blue_pin  = pwm_count < duty_b;
		res.red_cmp   = duty_r[CMP_OUT_W-1:0];
		res.green_cmp = duty_g[CMP_OUT_W-1:0];
		res.blue_cmp  = duty_b[CMP_OUT_W-1:0];
		res.lum       = lum_pct;
		return res;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch #%0d at %0t ns: %s got %0d expected %0d",
				fail_count, $time, what, got, want);
	endtask

	// predictor: track register writes and accepted transactions
	always @(posedge clk or negedge arst_n) begin : led_predictor
		led_cmd_t cmd;
		if (!arst_n) begin
			pwm_count  = '0;
			tick_count = '0;
			lum_pct    = FULL_LUM;
			duty_r     = 16'(RESET_DUTY);
			duty_g     = 16'(RESET_DUTY);
			duty_b     = 16'(RESET_DUTY);
			colour_r   = '0;
			colour_g   = '0;
			colour_b   = '0;
			dim_mode   = 1'b1;
			period_cfg = RESET_PERIOD;
			ticks_cfg  = RESET_TICKS;
			step_cfg   = RESET_STEP;
		end else begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.addr)
				REG_RED:       colour_r   = cfg_bus.data[COLOUR_W-1:0];
				REG_GREEN:     colour_g   = cfg_bus.data[COLOUR_W-1:0];
				REG_BLUE:      colour_b   = cfg_bus.data[COLOUR_W-1:0];
				REG_RAMP_DOWN: dim_mode   = cfg_bus.data[0];
				REG_PERIOD:    period_cfg = cfg_bus.data[PERIOD_W-1:0];
				REG_TICKS:     ticks_cfg  = cfg_bus.data[TICK_W-1:0];
				REG_LUM_STEP:  step_cfg   = cfg_bus.data[STEP_W-1:0];
				default: begin
				end
				endcase
			end
			if (item_bus.valid && item_bus.ready) begin
				cmd.opcode   = item_bus.opcode;
				cmd.lum_load = item_bus.luminance_value;
				led_state_q.push_back(advance_led_model(cmd));
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : cmd_driver
		led_cmd_t next_cmd;
		if (!arst_n) begin
			item_bus.valid           <= 1'b0;
			item_bus.opcode          <= OP_PWM_CLOCK;
			item_bus.luminance_value <= '0;
			gap_left = 0;
		end else if (item_bus.valid && !item_bus.ready) begin
			// hold the offered transaction
		end else if (gap_left > 0) begin
			item_bus.valid <= 1'b0;
			gap_left--;
		end else if (pending_cmds.size() != 0) begin
			next_cmd = pending_cmds.pop_front();
			item_bus.valid           <= 1'b1;
			item_bus.opcode          <= next_cmd.opcode;
			item_bus.luminance_value <= next_cmd.lum_load;
			gap_left = quiet_phase ? 0 : pick_gap();
		end else begin
			item_bus.valid <= 1'b0;
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		led_state_t want;
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
			stall_left  = 0;
			hold_served = 0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (led_state_q.size() == 0) begin
					report_mismatch("result with nothing pending, luminance_now",
						32'(result_bus.luminance_now), 0);
				end else begin
					want = led_state_q.pop_front();
					results_checked++;
					if (result_bus.red_pin !== want.red_pin)
						report_mismatch("red_pin", 32'(result_bus.red_pin),
							32'(want.red_pin));
					if (result_bus.green_pin !== want.green_pin)
						report_mismatch("green_pin", 32'(result_bus.green_pin),
							32'(want.green_pin));
					if (result_bus.blue_pin !== want.blue_pin)
						report_mismatch("blue_pin", 32'(result_bus.blue_pin),
							32'(want.blue_pin));
					if (result_bus.red_compare !== want.red_cmp)
						report_mismatch("red_compare", 32'(result_bus.red_compare),
							32'(want.red_cmp));
					if (result_bus.green_compare !== want.green_cmp)
						report_mismatch("green_compare", 32'(result_bus.green_compare),
							32'(want.green_cmp));
					if (result_bus.blue_compare !== want.blue_cmp)
						report_mismatch("blue_compare", 32'(result_bus.blue_compare),
							32'(want.blue_cmp));
					if (result_bus.luminance_now !== want.lum)
						report_mismatch("luminance_now", 32'(result_bus.luminance_now),
							32'(want.lum));
				end
			end
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				stall_left  = LONG_HOLD;
				result_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
				stall_left = quiet_phase ? 0 : pick_gap();
			end
		end
	end

	task automatic queue_item(logic [OPCODE_W-1:0] opcode, logic [LUM_IN_W-1:0] lum_load);
		led_cmd_t cmd;
		cmd.opcode   = opcode;
		cmd.lum_load = lum_load;
		pending_cmds.push_back(cmd);
		cmd_count[opcode]++;
	endtask

	task automatic queue_random_items(int n);
		int unsigned roll;
		logic [OPCODE_W-1:0] opcode;
		logic [LUM_IN_W-1:0] lum_load;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 50)
				opcode = OP_PWM_CLOCK;
			else if (roll < 80)
				opcode = OP_RAMP_TICK;
			else if (roll < 97)
				opcode = OP_LOAD_LUM;
			else
				opcode = OP_UNUSED;
			lum_load = LUM_IN_W'($urandom_range(0, 1) ? $urandom_range(0, 255) :
				$urandom_range(0, 100));
			queue_item(opcode, lum_load);
		end
	endtask

	// settle at a falling edge so no edge-time ordering matters
	task automatic wait_for_idle();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || item_bus.valid || led_state_q.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.addr  <= idx;
		cfg_bus.data  <= value[CFG_DATA_W-1:0];
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		reg_writes++;
	endtask

	task automatic apply_settings(int unsigned red, int unsigned green, int unsigned blue,
			int unsigned down, int unsigned period, int unsigned ticks, int unsigned step);
		write_reg(REG_RED, red);
		write_reg(REG_GREEN, green);
		write_reg(REG_BLUE, blue);
		write_reg(REG_RAMP_DOWN, down);
		write_reg(REG_PERIOD, period);
		write_reg(REG_TICKS, ticks);
		write_reg(REG_LUM_STEP, step);
		settings_applied++;
		@(negedge clk);
	endtask

	function automatic int unsigned random_colour();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return 255;
		return $urandom_range(0, 255);
	endfunction

	initial begin : stimulus
		int unsigned period, ticks, step;
		arst_n        <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.addr  <= REG_RED;
		cfg_bus.data  <= '0;
		quiet_phase   = 1'b0;
		hold_requests = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: counter climbs, spare opcode, load clamp and extremes
		repeat (3) queue_item(OP_PWM_CLOCK, '0);
		queue_item(OP_UNUSED, 8'hA5);
		queue_item(OP_LOAD_LUM, 8'd255);
		queue_item(OP_LOAD_LUM, 8'd101);
		queue_item(OP_LOAD_LUM, 8'd0);
		queue_item(OP_LOAD_LUM, 8'd100);
		wait_for_idle();

		// brighten with full step: saturate at the top, wrap at a short period
		apply_settings(255, 0, 128, 0, 3, 1, 100);
		queue_item(OP_RAMP_TICK, '0);
		queue_item(OP_LOAD_LUM, 8'd0);
		queue_item(OP_RAMP_TICK, '0);
		queue_item(OP_LOAD_LUM, 8'd50);
		queue_item(OP_RAMP_TICK, 8'hFF);
		repeat (4) queue_item(OP_PWM_CLOCK, '0);
		wait_for_idle();

		// period dropped under the counter; dim past zero and stop at the floor
		apply_settings(1, 255, 0, 1, 1, 1, 7);
		repeat (3) queue_item(OP_PWM_CLOCK, '0);
		queue_item(OP_LOAD_LUM, 8'd5);
		queue_item(OP_RAMP_TICK, '0);
		queue_item(OP_LOAD_LUM, 8'd9);
		queue_item(OP_RAMP_TICK, '0);
		queue_item(OP_RAMP_TICK, '0);
		wait_for_idle();

		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 2)
				period = 65535;
			else if (phase == 5)
				period = 1;
			else if ($urandom_range(0, 7) == 0)
				period = $urandom_range(1, 65535);
			else
				period = $urandom_range(2, 300);
			if (phase == 4)
				ticks = 255;
			else if (phase == 7)
				ticks = 1;
			else
				ticks = $urandom_range(1, 10);
			if (phase == 3)
				step = 100;
			else if (phase == 6)
				step = 1;
			else
				step = $urandom_range(1, 40);
			apply_settings(random_colour(), random_colour(), random_colour(),
				$urandom_range(0, 1), period, ticks, step);

			quiet_phase = (phase == 8) || (phase == 9);
			// back up the result side while the sender keeps offering
			if (phase == 8)
				hold_requests++;
			if (phase == 6) begin
				queue_random_items(64);
				wait_for_idle();
				queue_random_items(64);
			end else begin
				queue_random_items(128);
			end
			wait_for_idle();
		end

		quiet_phase = 1'b0;
		repeat (8) @(posedge clk);
		$display("Drove %0d PWM clocks, %0d ramp ticks, %0d luminance loads, %0d spare opcodes",
			cmd_count[OP_PWM_CLOCK], cmd_count[OP_RAMP_TICK], cmd_count[OP_LOAD_LUM],
			cmd_count[OP_UNUSED]);
		$display("Compared %0d results over %0d register settings (%0d writes)",
			results_checked, settings_applied, reg_writes);
		if (fail_count == 0 && led_state_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("timeout with %0d results still pending", led_state_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
